// File: rtl/pulse_period_capture_ring_macros.svh
// assertion macros for the pulse period capture ring
// no dependencies; included by the top level
`ifndef PULSE_PERIOD_CAPTURE_RING_MACROS_SVH
`define PULSE_PERIOD_CAPTURE_RING_MACROS_SVH

`ifndef SYNTHESIS

`define PPCR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppcr assertion failed: same-cycle implication");

`define PPCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppcr assertion failed: next-cycle implication");

`else

`define PPCR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define PPCR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/ppcr_pkg.sv
// shared types and constants of the pulse period capture ring
// no dependencies
package ppcr_pkg;

    localparam int DEFAULT_RING_DEPTH = 8;
    localparam int ACTION_W = 2;
    localparam int READ_INDEX_W = 3;
    localparam int PERIOD_W = 16;
    localparam int WRITE_INDEX_W = 3;
    localparam int ENTRIES_USED_W = 4;
    localparam logic [PERIOD_W-1:0] PERIOD_LIMIT_RESET = 16'hFFFF;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK  = 2'd0,
        ACT_PULSE = 2'd1,
        ACT_READ  = 2'd2
    } t_action;

endpackage

// File: rtl/ppcr_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module ppcr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/pulse_period_capture_ring.sv
// Pulse period capture ring: one action (tick, pulse or read) is taken per clock cycle
// while the output is free, and its result is in the output register in the cycle after
// the transfer. A finished result waiting on the output does not stop the next transfer
// once it is taken in the same cycle, so throughput is one item per cycle; the limit is
// the single state update plus the registered read of the entry ram. Entries live in a
// ram with one valid bit per entry cleared at reset, so an entry never written reads
// as zero and no clearing pass is needed. The period limit register is always ready.
// depends on ppcr_pkg, ppcr_ram and pulse_period_capture_ring_macros.svh
`include "pulse_period_capture_ring_macros.svh"

module pulse_period_capture_ring
    import ppcr_pkg::*;
#(
    parameter int RING_DEPTH = DEFAULT_RING_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [PERIOD_W-1:0]       i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [ACTION_W-1:0]       i_action,
    input  logic [READ_INDEX_W-1:0]   i_read_index,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [PERIOD_W-1:0]       o_period_value,
    output logic [WRITE_INDEX_W-1:0]  o_write_index,
    output logic [ENTRIES_USED_W-1:0] o_entries_used,
    output logic                      o_ring_full,
    output logic                      o_slow_flag,
    output logic                      o_overflowed
);

    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam logic [IDX_W:0] DEPTH_WIDE = (IDX_W + 1)'(RING_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(RING_DEPTH);

    logic [PERIOD_W-1:0] r_limit;
    logic [PERIOD_W-1:0] r_timer, n_timer;
    logic [IDX_W-1:0]    r_pos, n_pos;
    logic [CNT_W-1:0]    r_used, n_used;
    logic                r_full, n_full;
    logic                r_resync, n_resync;
    logic                r_slow, n_slow;
    logic [RING_DEPTH-1:0] r_entry_valid;

    logic                      r_out_valid;
    logic [PERIOD_W-1:0]       r_value, n_value;
    logic                      r_is_read, n_is_read;
    logic                      r_rd_hit;
    logic                      r_ovf, n_ovf;

    logic                 accept;
    logic [PERIOD_W:0]    timer_inc;
    logic [IDX_W:0]       pos_adv;
    logic                 we;
    logic [IDX_W-1:0]     raddr;
    logic                 rd_ok;
    logic [PERIOD_W-1:0]  ram_q;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;

    assign timer_inc = {1'b0, r_timer} + (PERIOD_W + 1)'(1);
    assign raddr     = IDX_W'(i_read_index);
    assign rd_ok     = int'(i_read_index) < RING_DEPTH;

    always_comb begin
        n_timer   = r_timer;
        n_pos     = r_pos;
        n_used    = r_used;
        n_full    = r_full;
        n_resync  = r_resync;
        n_slow    = r_slow;
        n_value   = '0;
        n_is_read = 1'b0;
        n_ovf     = 1'b0;
        we        = 1'b0;
        pos_adv   = {1'b0, r_pos};
        case (t_action'(i_action))
            ACT_TICK: begin
                if (timer_inc >= {1'b0, r_limit}) begin
                    n_pos    = '0;
                    n_full   = 1'b0;
                    n_resync = 1'b1;
                    n_slow   = 1'b1;
                    n_timer  = '0;
                    n_ovf    = 1'b1;
                end else begin
                    n_timer = timer_inc[PERIOD_W-1:0];
                end
            end
            ACT_PULSE: begin
                we = 1'b1;
                if (r_resync) begin
                    n_full   = 1'b0;
                    n_resync = 1'b0;
                    n_value  = '0;
                end else begin
                    n_slow  = 1'b0;
                    pos_adv = {1'b0, r_pos} + (IDX_W + 1)'(1);
                    n_value = r_timer;
                end
                if (!n_full) begin
                    n_used = CNT_W'(pos_adv + (IDX_W + 1)'(1));
                end
                if (pos_adv == DEPTH_WIDE) begin
                    n_pos  = '0;
                    n_used = DEPTH_CNT;
                    n_full = 1'b1;
                end else begin
                    n_pos = pos_adv[IDX_W-1:0];
                end
                n_timer = '0;
            end
            ACT_READ: begin
                n_is_read = 1'b1;
            end
            default: begin
                n_value = '0;
            end
        endcase
    end

    ppcr_ram #(
        .WIDTH (PERIOD_W),
        .DEPTH (RING_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (accept && we),
        .i_waddr (n_pos),
        .i_wdata (n_value),
        .i_re    (accept && n_is_read),
        .i_raddr (raddr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit       <= PERIOD_LIMIT_RESET;
            r_timer       <= '0;
            r_pos         <= '0;
            r_used        <= '0;
            r_full        <= 1'b0;
            r_resync      <= 1'b0;
            r_slow        <= 1'b0;
            r_entry_valid <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (accept) begin
                r_timer  <= n_timer;
                r_pos    <= n_pos;
                r_used   <= n_used;
                r_full   <= n_full;
                r_resync <= n_resync;
                r_slow   <= n_slow;
                if (we) begin
                    r_entry_valid[n_pos] <= 1'b1;
                end
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_value   <= n_value;
            r_is_read <= n_is_read;
            r_rd_hit  <= rd_ok && r_entry_valid[raddr];
            r_ovf     <= n_ovf;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_period_value = r_is_read ? (r_rd_hit ? ram_q : '0) : r_value;
    assign o_write_index  = WRITE_INDEX_W'(r_pos);
    assign o_entries_used = ENTRIES_USED_W'(r_used);
    assign o_ring_full    = r_full;
    assign o_slow_flag    = r_slow;
    assign o_overflowed   = r_ovf;

    `PPCR_ASSERT_IMPLIES(a_full_means_depth, i_clk, i_rst_n, r_full, r_used == DEPTH_CNT)
    `PPCR_ASSERT_IMPLIES(a_resync_is_slow, i_clk, i_rst_n, r_resync, r_slow)
    `PPCR_ASSERT_IMPLIES(a_ovf_marks, i_clk, i_rst_n, r_out_valid && r_ovf, r_slow && r_resync)
    `PPCR_ASSERT_IMPLIES(a_ovf_ring, i_clk, i_rst_n, r_out_valid && r_ovf, !r_full && r_pos == '0)
    `PPCR_ASSERT_NEXT(a_pulse_clears_timer, i_clk, i_rst_n, accept && we, r_timer == '0)

endmodule

// File: dv/tb_pulse_period_capture_ring.sv
// self-checking bench for pulse_period_capture_ring: ticks, pulses and reads over several
// period limits and idle mixes, each result checked against an in-bench ring predictor
// depends on ppcr_pkg and pulse_period_capture_ring
`timescale 1ns / 100ps

module tb_pulse_period_capture_ring;
    import ppcr_pkg::*;

    localparam int RING_DEPTH = DEFAULT_RING_DEPTH;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0]     action;
        logic [READ_INDEX_W-1:0] rd;
    } t_wheel_event;

    typedef struct packed {
        logic [PERIOD_W-1:0]       period;
        logic [WRITE_INDEX_W-1:0]  widx;
        logic [ENTRIES_USED_W-1:0] used;
        logic                      full;
        logic                      slow;
        logic                      ovf;
    } t_capture;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [PERIOD_W-1:0]       i_cfg_data = '0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic [ACTION_W-1:0]       i_action = '0;
    logic [READ_INDEX_W-1:0]   i_read_index = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic [PERIOD_W-1:0]       o_period_value;
    logic [WRITE_INDEX_W-1:0]  o_write_index;
    logic [ENTRIES_USED_W-1:0] o_entries_used;
    logic                      o_ring_full;
    logic                      o_slow_flag;
    logic                      o_overflowed;

    // predictor state
    logic [PERIOD_W-1:0] limit_shadow = PERIOD_LIMIT_RESET;
    logic [PERIOD_W-1:0] wheel_timer = '0;
    logic [PERIOD_W-1:0] period_mem [RING_DEPTH];
    int                  ring_pos = 0;
    int                  ring_used = 0;
    logic                ring_is_full = 1'b0;
    logic                resync_pending = 1'b0;
    logic                slow_seen = 1'b0;

    t_wheel_event        pending_events[$];
    t_capture            expected_captures[$];
    logic [PERIOD_W-1:0] limit_writes[$];
    t_wheel_event        next_event;
    t_capture            exp_cap;
    int                  events_queued = 0;
    int                  events_taken = 0;
    int                  cfg_queued = 0;
    int                  cfg_taken = 0;
    int                  sender_idle_pct = 0;
    int                  out_stall_pct = 0;
    int                  phase_limit = int'(PERIOD_LIMIT_RESET);
    int                  error_count = 0;
    int                  stall_cycles = 0;

    pulse_period_capture_ring #(
        .RING_DEPTH(RING_DEPTH)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_read_index  (i_read_index),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_period_value(o_period_value),
        .o_write_index (o_write_index),
        .o_entries_used(o_entries_used),
        .o_ring_full   (o_ring_full),
        .o_slow_flag   (o_slow_flag),
        .o_overflowed  (o_overflowed)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        foreach (period_mem[k]) period_mem[k] = '0;
    end

    function automatic t_capture predict_capture(logic [ACTION_W-1:0] act,
                                                 logic [READ_INDEX_W-1:0] rd);
        t_capture   c;
        logic [16:0] nxt;
        c = '0;
        case (act)
            ACT_TICK: begin
                nxt = {1'b0, wheel_timer} + 17'd1;
                if (nxt >= {1'b0, limit_shadow}) begin
                    ring_pos = 0;
                    ring_is_full = 1'b0;
                    resync_pending = 1'b1;
                    slow_seen = 1'b1;
                    wheel_timer = '0;
                    c.ovf = 1'b1;
                end else begin
                    wheel_timer = nxt[PERIOD_W-1:0];
                end
            end
            ACT_PULSE: begin
                if (resync_pending) begin
                    ring_is_full = 1'b0;
                    resync_pending = 1'b0;
                    wheel_timer = '0;
                end else begin
                    slow_seen = 1'b0;
                    ring_pos++;
                end
                if (!ring_is_full) ring_used = ring_pos + 1;
                if (ring_pos >= RING_DEPTH) begin
                    ring_pos = 0;
                    ring_used = RING_DEPTH;
                    ring_is_full = 1'b1;
                end
                period_mem[ring_pos] = wheel_timer;
                wheel_timer = '0;
                c.period = period_mem[ring_pos];
            end
            ACT_READ: begin
                if (rd < RING_DEPTH) c.period = period_mem[rd];
            end
            default: ;
        endcase
        c.widx = ring_pos[WRITE_INDEX_W-1:0];
        c.used = ring_used[ENTRIES_USED_W-1:0];
        c.full = ring_is_full;
        c.slow = slow_seen;
        return c;
    endfunction

    function automatic void check_field(string fname, logic [PERIOD_W-1:0] exp_v,
                                        logic [PERIOD_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, fname, exp_v, act_v);
            error_count++;
        end
    endfunction

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_captures.push_back(predict_capture(i_action, i_read_index));
                events_taken++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_events.size() != 0 &&
                    $urandom_range(0, 99) >= sender_idle_pct) begin
                    next_event = pending_events.pop_front();
                    i_action <= next_event.action;
                    i_read_index <= next_event.rd;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // period limit writes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_cfg_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                limit_shadow = i_cfg_data;
                cfg_taken++;
            end
            if (!i_cfg_valid || o_cfg_ready) begin
                if (limit_writes.size() != 0) begin
                    i_cfg_data <= limit_writes.pop_front();
                    i_cfg_valid <= 1'b1;
                end else begin
                    i_cfg_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_captures.size() == 0) begin
                $display("%0t ns: result with nothing expected, expected none, actual %0d",
                         $time, o_period_value);
                error_count++;
            end else begin
                exp_cap = expected_captures.pop_front();
                check_field("period_value", exp_cap.period, o_period_value);
                check_field("write_index", PERIOD_W'(exp_cap.widx), PERIOD_W'(o_write_index));
                check_field("entries_used", PERIOD_W'(exp_cap.used),
                            PERIOD_W'(o_entries_used));
                check_field("ring_full", PERIOD_W'(exp_cap.full), PERIOD_W'(o_ring_full));
                check_field("slow_flag", PERIOD_W'(exp_cap.slow), PERIOD_W'(o_slow_flag));
                check_field("overflowed", PERIOD_W'(exp_cap.ovf), PERIOD_W'(o_overflowed));
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_pulse_period_capture_ring: errors");
                $finish;
            end
        end
    end

    task automatic push_event(logic [ACTION_W-1:0] act, logic [READ_INDEX_W-1:0] rd);
        t_wheel_event ev;
        ev.action = act;
        ev.rd = rd;
        pending_events.push_back(ev);
        events_queued++;
    endtask

    task automatic push_ticks(int n);
        repeat (n) push_event(ACT_TICK, READ_INDEX_W'($urandom_range(0, 7)));
    endtask

    task automatic wait_drained();
        while (events_taken != events_queued || expected_captures.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_limit(int v);
        phase_limit = v;
        limit_writes.push_back(PERIOD_W'(v));
        cfg_queued++;
        while (cfg_taken != cfg_queued) @(posedge i_clk);
    endtask

    task automatic queue_random_traffic(int n);
        int count;
        int r;
        int k;
        int k_max;
        count = 0;
        while (count < n) begin
            r = $urandom_range(0, 99);
            k_max = (phase_limit > 2) ? phase_limit - 2 : 0;
            if (r < 62) begin
                // one well-formed period: ticks below the limit, then a pulse
                if ($urandom_range(0, 19) == 0) begin
                    k = $urandom_range(0, (k_max > 400) ? 400 : k_max);
                end else begin
                    k = $urandom_range(0, (k_max > 30) ? 30 : k_max);
                end
                push_ticks(k);
                push_event(ACT_PULSE, READ_INDEX_W'($urandom_range(0, 7)));
                count += k + 1;
            end else if (r < 72) begin
                // run past a limit of at most 64, else a short run of ticks; then a pulse
                k = (phase_limit <= 64) ? phase_limit + $urandom_range(0, 3)
                                        : $urandom_range(1, 20);
                push_ticks(k);
                push_event(ACT_PULSE, READ_INDEX_W'($urandom_range(0, 7)));
                count += k + 1;
            end else if (r < 86) begin
                push_event(ACT_READ, READ_INDEX_W'($urandom_range(0, 7)));
                count++;
            end else if (r < 93) begin
                push_event(ACT_PULSE, READ_INDEX_W'($urandom_range(0, 7)));
                count++;
            end else if (r < 96) begin
                push_event(ACT_NONE, READ_INDEX_W'($urandom_range(0, 7)));
                count++;
            end else begin
                push_ticks(1);
                count++;
            end
        end
    endtask

    task automatic set_idling(int sender_pct, int stall_pct);
        sender_idle_pct = sender_pct;
        out_stall_pct = stall_pct;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset limit: empty reads, first periods, ring wrap
        set_idling(0, 0);
        push_event(ACT_READ, 3'd0);
        push_event(ACT_READ, 3'd7);
        push_event(ACT_PULSE, 3'd0);
        push_ticks(3);
        push_event(ACT_PULSE, 3'd7);
        push_event(ACT_NONE, 3'd7);
        push_event(ACT_READ, 3'd2);
        repeat (7) push_event(ACT_PULSE, 3'd0);
        push_event(ACT_READ, 3'd0);
        wait_drained();

        // minimum limit: every tick overflows, resync pulse stores zero
        set_limit(1);
        push_ticks(1);
        push_event(ACT_PULSE, 3'd0);
        push_event(ACT_PULSE, 3'd0);
        push_ticks(1);
        push_event(ACT_READ, 3'd1);
        queue_random_traffic(40);
        wait_drained();

        // zero limit
        set_limit(0);
        push_ticks(2);
        push_event(ACT_PULSE, 3'd0);
        push_event(ACT_PULSE, 3'd0);
        push_event(ACT_READ, 3'd0);
        wait_drained();

        set_limit(12);
        set_idling(87, 0);
        queue_random_traffic(90);
        wait_drained();

        set_limit(int'(PERIOD_LIMIT_RESET));
        set_idling(0, 87);
        queue_random_traffic(90);
        wait_drained();

        set_limit(37);
        set_idling(21, 21);
        queue_random_traffic(90);
        wait_drained();

        set_limit($urandom_range(2, 50));
        set_idling(0, 0);
        queue_random_traffic(90);
        wait_drained();

        set_limit(5);
        set_idling(87, 87);
        queue_random_traffic(60);
        wait_drained();

        repeat (5) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_pulse_period_capture_ring: clean");
        end else begin
            $display("tb_pulse_period_capture_ring: errors");
        end
        $finish;
    end

endmodule
